// File: src/asld_pkg.sv
`default_nettype none

package asld_pkg;

    localparam int PCM_W       = 24;
    localparam int POS_W       = 36;
    localparam int LVL_W       = 25;
    localparam int THR_W       = 25;
    localparam int SW_W        = 5;
    localparam int MAG_W       = 48;
    localparam int LVL_FRAC    = 20;
    localparam int PROD_B_W    = 36;
    localparam int LVL_SUM_W   = 46;
    localparam int DB_W        = 16;
    localparam int NORM_W      = 31;
    localparam int SQ_W        = 62;
    localparam int LOG_FRAC_W  = 16;
    localparam int MSB_W       = 5;
    localparam int NEG_W       = 21;
    localparam int DB_PROD_W   = 40;
    localparam int NUM_SQUARES = 16;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 36;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_LIMIT  = 2'd2;

    localparam logic [SW_W-1:0]  SAMPLE_WIDTH_MIN   = 5'd4;
    localparam logic [SW_W-1:0]  SAMPLE_WIDTH_RESET = 5'd16;

    localparam logic [19:0]      LVL_A      = 20'd1047527;
    localparam logic [10:0]      LVL_B      = 11'd1049;
    localparam logic [LVL_W-1:0] FULL_SCALE = 25'h1000000;
    localparam logic [MAG_W-1:0] FULL_SCALE_MAG = 48'h000001000000;

    localparam logic [18:0]      DB_K       = 19'd394566;
    localparam logic [DB_PROD_W-1:0] DB_ROUND = 40'h0000800000;
    localparam logic [DB_W-1:0]  DB_FLOOR   = 16'd24576;
    localparam logic [MSB_W-1:0] LOG_INT_TOP = 5'd24;
    localparam logic [MSB_W-1:0] NORM_TOP    = 5'd30;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = 3;
    localparam int QUEUE_CW    = 4;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             silent;
        logic [POS_W-1:0] position;
        logic             flush;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic                empty;
        logic [QUEUE_CW-1:0] count;
    } queue_status_t;

    typedef struct packed {
        logic [NORM_W-1:0]     norm;
        logic [LOG_FRAC_W-1:0] frac;
        logic [MSB_W-1:0]      msb;
        logic                  is_zero;
        logic                  is_full;
        logic                  silent;
        logic [POS_W-1:0]      position;
        logic                  flush;
    } log_stage_t;

endpackage

`default_nettype wire

// File: src/asld_front.sv
`default_nettype none

module asld_front #(
    parameter int MAX_SAMPLE_BITS = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [asld_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                                s_tuser,
    input  wire logic                                s_tlast,
    input  wire logic                                cfg_wr_en,
    input  wire logic [asld_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [asld_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire asld_pkg::queue_status_t             queue_status,
    output asld_pkg::push_t                          push
);

    localparam logic [5:0] MAX_W = 6'(MAX_SAMPLE_BITS);

    logic [asld_pkg::THR_W-1:0] threshold_reg;
    logic [asld_pkg::SW_W-1:0]  sample_width_reg;
    logic [asld_pkg::POS_W-1:0] flush_limit_reg;

    logic                        a_valid_reg;
    logic [asld_pkg::PCM_W-1:0]  a_abs_reg;
    logic                        a_first_reg;
    logic                        a_last_reg;
    logic [asld_pkg::POS_W-1:0]  a_pos_reg;

    logic                           b_valid_reg;
    logic                           b_loud_reg;
    logic [asld_pkg::PROD_B_W-1:0]  b_prod_reg;
    logic                           b_first_reg;
    logic                           b_last_reg;
    logic [asld_pkg::POS_W-1:0]     b_pos_reg;
    logic                           b_flush_reg;

    logic [asld_pkg::LVL_W-1:0] level_reg;
    logic [asld_pkg::LVL_W-1:0] level_next;
    logic                       silence_reg;
    logic                       silence_next;

    logic                           accept;
    logic [asld_pkg::PCM_W-1:0]     sample;
    logic [asld_pkg::PCM_W-1:0]     abs_next;
    logic [asld_pkg::POS_W-1:0]     pos_in;
    logic [asld_pkg::SW_W-1:0]      width_eff;
    logic [asld_pkg::MAG_W-1:0]     mag;
    logic [asld_pkg::LVL_W-1:0]     lvl_in;
    logic [asld_pkg::PROD_B_W-1:0]  prod_next;
    logic                           loud_next;
    logic                           flush_next;
    logic [asld_pkg::LVL_SUM_W-1:0] lvl_sum;
    logic [asld_pkg::QUEUE_CW:0]    pending;

    assign sample   = s_tdata[asld_pkg::PCM_W-1:0];
    assign pos_in   = s_tdata[asld_pkg::PCM_W +: asld_pkg::POS_W];
    assign abs_next = sample[asld_pkg::PCM_W-1] ? (~sample + 1'b1) : sample;

    assign pending  = {1'b0, queue_status.count}
                    + (asld_pkg::QUEUE_CW+1)'(a_valid_reg & a_last_reg)
                    + (asld_pkg::QUEUE_CW+1)'(b_valid_reg & b_last_reg);
    assign s_tready = (pending < (asld_pkg::QUEUE_CW+1)'(asld_pkg::QUEUE_DEPTH));
    assign accept   = s_tvalid & s_tready;

    always_comb
    begin
        if (sample_width_reg < asld_pkg::SAMPLE_WIDTH_MIN)
        begin
            width_eff = asld_pkg::SAMPLE_WIDTH_MIN;
        end
        else if ({1'b0, sample_width_reg} > MAX_W)
        begin
            width_eff = MAX_W[asld_pkg::SW_W-1:0];
        end
        else
        begin
            width_eff = sample_width_reg;
        end
    end

    always_comb
    begin
        mag       = {a_abs_reg, {asld_pkg::PCM_W{1'b0}}} >> (width_eff - 1'b1);
        lvl_in    = (mag > asld_pkg::FULL_SCALE_MAG) ? asld_pkg::FULL_SCALE
                                                     : mag[asld_pkg::LVL_W-1:0];
        prod_next = asld_pkg::PROD_B_W'(lvl_in * asld_pkg::LVL_B);
        loud_next = mag > asld_pkg::MAG_W'(threshold_reg);
        flush_next = (flush_limit_reg != '0) && (a_pos_reg >= flush_limit_reg);
    end

    always_comb
    begin
        lvl_sum      = asld_pkg::LVL_SUM_W'(level_reg * asld_pkg::LVL_A)
                     + asld_pkg::LVL_SUM_W'(b_prod_reg);
        level_next   = lvl_sum[asld_pkg::LVL_FRAC +: asld_pkg::LVL_W];
        silence_next = (b_first_reg | silence_reg) & ~b_loud_reg;
    end

    assign push.valid          = b_valid_reg & b_last_reg;
    assign push.entry.level    = level_next;
    assign push.entry.silent   = silence_next;
    assign push.entry.position = b_pos_reg;
    assign push.entry.flush    = b_flush_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= '0;
            sample_width_reg <= asld_pkg::SAMPLE_WIDTH_RESET;
            flush_limit_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                asld_pkg::CFG_THRESHOLD:
                begin
                    threshold_reg <= cfg_wdata[asld_pkg::THR_W-1:0];
                end
                asld_pkg::CFG_SAMPLE_WIDTH:
                begin
                    sample_width_reg <= cfg_wdata[asld_pkg::SW_W-1:0];
                end
                asld_pkg::CFG_FLUSH_LIMIT:
                begin
                    flush_limit_reg <= cfg_wdata[asld_pkg::POS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            level_reg   <= '0;
            silence_reg <= 1'b1;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            if (b_valid_reg)
            begin
                level_reg   <= level_next;
                silence_reg <= silence_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_abs_reg   <= abs_next;
            a_first_reg <= s_tuser;
            a_last_reg  <= s_tlast;
            a_pos_reg   <= pos_in;
        end
        if (a_valid_reg)
        begin
            b_loud_reg  <= loud_next;
            b_prod_reg  <= prod_next;
            b_first_reg <= a_first_reg;
            b_last_reg  <= a_last_reg;
            b_pos_reg   <= a_pos_reg;
            b_flush_reg <= flush_next;
        end
    end

endmodule

`default_nettype wire

// File: src/asld_queue.sv
`default_nettype none

module asld_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire asld_pkg::push_t         push,
    input  wire logic                    pop,
    output asld_pkg::entry_t             head,
    output asld_pkg::queue_status_t      status
);

    asld_pkg::entry_t              entries_reg [asld_pkg::QUEUE_DEPTH];
    logic [asld_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [asld_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [asld_pkg::QUEUE_CW-1:0] count_reg;
    logic [asld_pkg::QUEUE_CW-1:0] count_next;
    logic                          do_pop;

    assign do_pop       = pop & (count_reg != '0);
    assign head         = entries_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

// File: src/asld_log_pipe.sv
`default_nettype none

module asld_log_pipe (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire asld_pkg::queue_status_t             queue_status,
    input  wire asld_pkg::entry_t                    head,
    output logic                                     pop,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [asld_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    localparam int NS = asld_pkg::NUM_SQUARES;

    logic                   valid_reg [NS+1];
    asld_pkg::log_stage_t   stage_reg [NS+1];
    asld_pkg::log_stage_t   stage0_next;

    logic                          advance;
    logic [asld_pkg::MSB_W-1:0]    msb;

    logic                             m_tvalid_reg;
    logic [asld_pkg::DB_W-1:0]        db_reg;
    logic [asld_pkg::DB_W-1:0]        db_next;
    logic                             silent_reg;
    logic [asld_pkg::POS_W-1:0]       pos_reg;
    logic                             flush_reg;

    logic [asld_pkg::MSB_W-1:0]       int_part;
    logic [asld_pkg::NEG_W-1:0]       neg;
    logic [asld_pkg::DB_PROD_W-1:0]   db_prod;
    logic [asld_pkg::DB_W-1:0]        db_mag;

    assign advance = ~m_tvalid_reg | m_tready;
    assign pop     = advance & ~queue_status.empty;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < asld_pkg::PCM_W; i++)
        begin
            if (head.level[i])
            begin
                msb = asld_pkg::MSB_W'(i);
            end
        end
    end

    always_comb
    begin
        stage0_next.norm     = asld_pkg::NORM_W'(head.level[asld_pkg::PCM_W-1:0])
                             << (asld_pkg::NORM_TOP - msb);
        stage0_next.frac     = '0;
        stage0_next.msb      = msb;
        stage0_next.is_zero  = (head.level == '0);
        stage0_next.is_full  = head.level[asld_pkg::LVL_W-1];
        stage0_next.silent   = head.silent;
        stage0_next.position = head.position;
        stage0_next.flush    = head.flush;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= ~queue_status.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= stage0_next;
        end
    end

    for (genvar k = 1; k <= NS; k++)
    begin : g_square
        logic [asld_pkg::SQ_W-1:0]   sq;
        logic [asld_pkg::NORM_W:0]   sq_top;
        asld_pkg::log_stage_t        next;

        always_comb
        begin
            sq     = asld_pkg::SQ_W'(stage_reg[k-1].norm * stage_reg[k-1].norm);
            sq_top = sq[asld_pkg::SQ_W-1:asld_pkg::NORM_W-1];
            next   = stage_reg[k-1];
            if (sq_top[asld_pkg::NORM_W])
            begin
                next.norm = sq_top[asld_pkg::NORM_W:1];
                next.frac = {stage_reg[k-1].frac[asld_pkg::LOG_FRAC_W-2:0], 1'b1};
            end
            else
            begin
                next.norm = sq_top[asld_pkg::NORM_W-1:0];
                next.frac = {stage_reg[k-1].frac[asld_pkg::LOG_FRAC_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_reg[k] <= next;
            end
        end
    end

    always_comb
    begin
        int_part = asld_pkg::LOG_INT_TOP - stage_reg[NS].msb;
        neg      = {int_part, {asld_pkg::LOG_FRAC_W{1'b0}}}
                 - asld_pkg::NEG_W'(stage_reg[NS].frac);
        db_prod  = asld_pkg::DB_PROD_W'(neg * asld_pkg::DB_K) + asld_pkg::DB_ROUND;
        db_mag   = db_prod[asld_pkg::DB_PROD_W-1 -: asld_pkg::DB_W];
        priority if (stage_reg[NS].is_zero)
        begin
            db_next = -asld_pkg::DB_FLOOR;
        end
        else if (stage_reg[NS].is_full)
        begin
            db_next = '0;
        end
        else if (db_mag >= asld_pkg::DB_FLOOR)
        begin
            db_next = -asld_pkg::DB_FLOOR;
        end
        else
        begin
            db_next = -db_mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            db_reg     <= db_next;
            silent_reg <= stage_reg[NS].silent;
            pos_reg    <= stage_reg[NS].position;
            flush_reg  <= stage_reg[NS].flush;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, flush_reg, pos_reg, silent_reg, db_reg};

endmodule

`default_nettype wire

// File: src/audio_silence_level_detector_top.sv
// Audio silence and level detector. Takes one PCM sample per cycle on the
// slave stream while s_tready is high, with tuser marking the first sample
// of a frame and tlast the last. Each sample's magnitude, normalized by
// sample_width, drives an exponential level follower (level*0.999 +
// mag*0.001, Q1.24, never cleared between frames) and a per-frame silence
// test against threshold_level. After the last sample of a frame one
// transaction leaves on the master stream with the level in Q8.8 dB (clamped
// to -96..0), the silence flag, the frame position and the flush flag.
// Samples are accepted at one per cycle while s_tready is high; results
// queue in an 8-entry buffer ahead of the dB unit, and tready drops only when
// that buffer, plus frame ends still in the two-stage front end, would
// overflow because results are not being taken. From the edge that accepts
// the last sample of a frame, the result passes the two front-end stages,
// the queue, a normalize stage, sixteen squaring stages of the log2 unit and
// the output register that drives m_tvalid; the log2 stages hold while an
// output waits on m_tready. Write configuration only while idle.
`default_nettype none

module audio_silence_level_detector_top #(
    parameter int MAX_SAMPLE_BITS = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // pcm_sample[23:0], frame_position[59:24], zero[63:60]
    input  wire logic [asld_pkg::IN_TDATA_W-1:0]     s_tdata,
    // frame_first
    input  wire logic                                s_tuser,
    input  wire logic                                s_tlast,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // level_db[15:0], frame_silent[16], position_out[52:17], flush_flag[53],
    // zero[55:54]
    output logic [asld_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_wr_en,
    input  wire logic [asld_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [asld_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    asld_pkg::push_t         push;
    asld_pkg::entry_t        head;
    asld_pkg::queue_status_t queue_status;
    logic                    pop;

    asld_front #(
        .MAX_SAMPLE_BITS(MAX_SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .queue_status (queue_status),
        .push         (push)
    );

    asld_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (queue_status)
    );

    asld_log_pipe u_log_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .head         (head),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

`default_nettype wire

// File: tb/tb_audio_silence_level_detector_top.sv
`timescale 1ns / 100ps

module tb_audio_silence_level_detector_top;

    localparam logic [63:0] LEVEL_KEEP        = 64'd1047527;
    localparam logic [63:0] LEVEL_GAIN        = 64'd1049;
    localparam logic [63:0] FULL_SCALE_LVL    = 64'h100_0000;
    localparam logic [63:0] NORM_TWO          = 64'h8000_0000;
    localparam logic [63:0] DB_PER_OCTAVE_Q16 = 64'd394566;
    localparam logic [63:0] DB_ROUND_HALF     = 64'h80_0000;
    localparam int          DB_FLOOR_Q8       = 24576;
    localparam int          SAMPLE_BITS_MIN   = 4;
    localparam int          SAMPLE_BITS_MAX   = 24;
    localparam logic [35:0] POS_MAX           = 36'hF_FFFF_FFFF;
    localparam logic [asld_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int          SETTLE_CYCLES     = 40;
    localparam int          LONG_HOLD         = 300;
    localparam int          WATCHDOG_LIMIT    = 2000;
    localparam int          RANDOM_PHASES     = 8;
    localparam int          ITEMS_PER_PHASE   = 70;
    localparam int          SATURATE_ITEMS    = 50;
    localparam int          SATURATE_FRAME    = 25;

    typedef struct {
        logic [23:0] sample;
        logic        first;
        logic        last;
        logic [35:0] position;
    } pcm_item_t;

    typedef struct {
        logic signed [15:0] db;
        logic               silent;
        logic [35:0]        position;
        logic               flush;
    } level_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic [asld_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             s_tuser = 1'b0;
    logic                             s_tlast = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [asld_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [asld_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [asld_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    pcm_item_t     pending_samples[$];
    level_report_t pending_reports[$];

    logic [24:0] level_acc = '0;
    logic        quiet_frame = 1'b1;
    logic [24:0] cfg_threshold = '0;
    logic [4:0]  cfg_width = 5'd16;
    logic [35:0] cfg_flush_limit = '0;

    bit          src_idle_on = 1'b0;
    bit          sink_idle_on = 1'b0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          src_gap = 0;
    int          sink_stall = 0;
    int          quiet_cycles = 0;
    int          mismatch_count = 0;
    logic [35:0] next_position = '0;

    audio_silence_level_detector_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int effective_width();
        int w;
        w = int'(cfg_width);
        if (w < SAMPLE_BITS_MIN)
            w = SAMPLE_BITS_MIN;
        if (w > SAMPLE_BITS_MAX)
            w = SAMPLE_BITS_MAX;
        return w;
    endfunction

    function automatic logic signed [15:0] level_in_db(input logic [24:0] lvl);
        logic [63:0] norm;
        logic [63:0] neg;
        logic [63:0] db_mag;
        logic [15:0] frac;
        int          msb;
        if (lvl == '0)
            return 16'(-DB_FLOOR_Q8);
        if (64'(lvl) >= FULL_SCALE_LVL)
            return '0;
        msb = 0;
        while (msb < 24 && (lvl >> (msb + 1)) != 0)
            msb++;
        norm = 64'(lvl) << (30 - msb);
        frac = '0;
        for (int i = 0; i < 16; i++)
        begin
            norm = (norm * norm) >> 30;
            frac = frac << 1;
            if (norm >= NORM_TWO)
            begin
                norm = norm >> 1;
                frac[0] = 1'b1;
            end
        end
        neg = (64'(24 - msb) << 16) - 64'(frac);
        db_mag = (neg * DB_PER_OCTAVE_Q16 + DB_ROUND_HALF) >> 24;
        if (db_mag >= 64'(DB_FLOOR_Q8))
            return 16'(-DB_FLOOR_Q8);
        return 16'(-int'(db_mag));
    endfunction

    function automatic void absorb_sample(input logic [23:0] raw, input logic is_first,
                                          input logic is_last, input logic [35:0] pos);
        logic [63:0]   absval;
        logic [63:0]   mag;
        logic [63:0]   lvl_in;
        level_report_t rpt;
        absval = raw[23] ? 64'h100_0000 - 64'(raw) : 64'(raw);
        mag = (absval << 24) >> (effective_width() - 1);
        lvl_in = (mag > FULL_SCALE_LVL) ? FULL_SCALE_LVL : mag;
        level_acc = 25'((64'(level_acc) * LEVEL_KEEP + lvl_in * LEVEL_GAIN) >> 20);
        if (is_first)
            quiet_frame = 1'b1;
        if (mag > 64'(cfg_threshold))
            quiet_frame = 1'b0;
        if (is_last)
        begin
            rpt.db = level_in_db(level_acc);
            rpt.silent = quiet_frame;
            rpt.position = pos;
            rpt.flush = (cfg_flush_limit != '0) && (pos >= cfg_flush_limit);
            pending_reports.push_back(rpt);
        end
    endfunction

    function automatic logic [23:0] rand_sample(input int amp);
        int span;
        span = 1 << amp;
        return 24'(int'($urandom_range(0, 2 * span - 1)) - span);
    endfunction

    function automatic logic [35:0] rand_position();
        return {4'($urandom_range(0, 15)), 32'($urandom)};
    endfunction

    always @(posedge clk)
    begin : drive_samples
        pcm_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_gap != 0)
            begin
                s_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (pending_samples.size() != 0)
            begin
                nxt = pending_samples.pop_front();
                s_tdata <= {4'b0, nxt.position, nxt.sample};
                s_tuser <= nxt.first;
                s_tlast <= nxt.last;
                s_tvalid <= 1'b1;
                if (src_idle_on && $urandom_range(0, 5) == 0)
                    src_gap <= $urandom_range(1, 6);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : drive_ready
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            sink_stall <= LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else if (sink_stall != 0)
        begin
            sink_stall <= sink_stall - 1;
            m_tready <= 1'b0;
        end
        else if (sink_idle_on && $urandom_range(0, 4) == 0)
        begin
            sink_stall <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : track_level
        level_report_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    asld_pkg::CFG_THRESHOLD:    cfg_threshold = cfg_wdata[24:0];
                    asld_pkg::CFG_SAMPLE_WIDTH: cfg_width = cfg_wdata[4:0];
                    asld_pkg::CFG_FLUSH_LIMIT:  cfg_flush_limit = cfg_wdata[35:0];
                    default:                    ;
                endcase
            end
            if (s_tvalid && s_tready)
                absorb_sample(s_tdata[23:0], s_tuser, s_tlast, s_tdata[59:24]);
            if (m_tvalid && m_tready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("level report with none expected: tdata=%h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if ($signed(m_tdata[15:0]) !== want.db)
                    begin
                        $error("level_db: expected %0d, got %0d", want.db,
                               $signed(m_tdata[15:0]));
                        mismatch_count++;
                    end
                    if (m_tdata[16] !== want.silent)
                    begin
                        $error("frame_silent: expected %0b, got %0b", want.silent,
                               m_tdata[16]);
                        mismatch_count++;
                    end
                    if (m_tdata[52:17] !== want.position)
                    begin
                        $error("position_out: expected %h, got %h", want.position,
                               m_tdata[52:17]);
                        mismatch_count++;
                    end
                    if (m_tdata[53] !== want.flush)
                    begin
                        $error("flush_flag: expected %0b, got %0b", want.flush,
                               m_tdata[53]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("audio_silence_level_detector_top: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [asld_pkg::CFG_IDX_W-1:0] idx,
                             input logic [35:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_samples.size() != 0 || s_tvalid || pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [23:0] s, input logic f, input logic l,
                                input logic [35:0] p);
        pcm_item_t it;
        it.sample = s;
        it.first = f;
        it.last = l;
        it.position = p;
        pending_samples.push_back(it);
    endtask

    task automatic queue_frame(output int n);
        int          len;
        int          kind;
        int          w;
        bit          noisy;
        logic [35:0] pos;
        logic [23:0] s;
        w = effective_width();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        kind = $urandom_range(0, 5);
        noisy = ($urandom_range(0, 6) == 0);
        case ($urandom_range(0, 3))
            0:       pos = rand_position();
            1:       pos = cfg_flush_limit + 36'($urandom_range(0, 4)) - 36'd2;
            2:       pos = next_position;
            default: pos = 36'($urandom_range(0, 1000));
        endcase
        next_position = pos + 36'(len);
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                0:       s = '0;
                1:       s = 24'($urandom);
                2:       s = rand_sample(w - 1);
                3:       s = rand_sample($urandom_range(0, w - 1));
                4:
                begin
                    case ($urandom_range(0, 3))
                        0:       s = 24'h800000;
                        1:       s = 24'h7FFFFF;
                        2:       s = 24'(-(1 << (w - 1)));
                        default: s = 24'((1 << (w - 1)) - 1);
                    endcase
                end
                default: s = rand_sample($urandom_range(0, 23));
            endcase
            if (noisy)
                queue_sample(s, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, pos);
            else
                queue_sample(s, i == 0, i == len - 1, pos);
        end
        n = len;
    endtask

    task automatic apply_random_config();
        logic [24:0] thr;
        logic [4:0]  sw;
        logic [35:0] lim;
        case ($urandom_range(0, 5))
            0:       thr = '0;
            1:       thr = 25'h100_0000;
            2:       thr = 25'h1FF_FFFF;
            3:       thr = 25'($urandom);
            default: thr = (25'd1 << $urandom_range(8, 24)) | 25'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 4))
            0:       sw = 5'($urandom_range(0, 31));
            1:       sw = 5'd8;
            2:       sw = 5'd16;
            3:       sw = 5'd24;
            default: sw = 5'($urandom_range(4, 24));
        endcase
        case ($urandom_range(0, 3))
            0:       lim = '0;
            1:       lim = rand_position();
            2:       lim = POS_MAX;
            default: lim = 36'($urandom_range(1, 2000));
        endcase
        cfg_write(asld_pkg::CFG_THRESHOLD, 36'(thr));
        cfg_write(asld_pkg::CFG_SAMPLE_WIDTH, 36'(sw));
        cfg_write(asld_pkg::CFG_FLUSH_LIMIT, lim);
    endtask

    initial
    begin : run_test
        int          queued;
        int          n;
        logic [23:0] s;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;

        queue_sample(24'h000000, 1'b1, 1'b1, 36'd0);
        queue_sample(24'h000002, 1'b1, 1'b1, 36'd1);
        queue_sample(24'h000000, 1'b1, 1'b1, 36'd2);
        queue_sample(24'h800000, 1'b1, 1'b0, POS_MAX);
        queue_sample(24'h7FFFFF, 1'b0, 1'b0, POS_MAX);
        queue_sample(24'h007FFF, 1'b0, 1'b1, POS_MAX);
        queue_sample(24'hFFFFFF, 1'b1, 1'b1, 36'd3);
        queue_sample(24'h000000, 1'b0, 1'b1, 36'd4);
        queue_sample(24'hFF8000, 1'b1, 1'b0, 36'd5);
        queue_sample(24'h000064, 1'b0, 1'b0, 36'd5);
        queue_sample(24'h000000, 1'b0, 1'b1, 36'd5);
        wait_idle();

        cfg_write(asld_pkg::CFG_THRESHOLD, 36'h100_0000);
        cfg_write(asld_pkg::CFG_SAMPLE_WIDTH, 36'd4);
        cfg_write(asld_pkg::CFG_FLUSH_LIMIT, POS_MAX);
        @(negedge clk);
        queue_sample(24'h000007, 1'b1, 1'b1, POS_MAX);
        queue_sample(24'hFFFFF8, 1'b1, 1'b1, POS_MAX - 36'd1);
        queue_sample(24'h000009, 1'b1, 1'b1, 36'd0);
        wait_idle();

        cfg_write(asld_pkg::CFG_THRESHOLD, 36'd0);
        cfg_write(asld_pkg::CFG_SAMPLE_WIDTH, 36'd0);
        cfg_write(asld_pkg::CFG_FLUSH_LIMIT, 36'd1);
        cfg_write(CFG_SPARE, rand_position());
        @(negedge clk);
        queue_sample(24'h000007, 1'b1, 1'b1, 36'd0);
        queue_sample(24'hFFFFFD, 1'b1, 1'b1, 36'd1);
        wait_idle();

        cfg_write(asld_pkg::CFG_THRESHOLD, 36'($urandom_range(0, 25'h1FF_FFFF)));
        cfg_write(asld_pkg::CFG_SAMPLE_WIDTH, 36'd31);
        cfg_write(asld_pkg::CFG_FLUSH_LIMIT, 36'h8_0000_0000);
        @(negedge clk);
        queue_sample(24'h7FFFFF, 1'b1, 1'b1, 36'h8_0000_0000);
        queue_sample(24'h800000, 1'b1, 1'b1, 36'h7_FFFF_FFFF);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            apply_random_config();
            @(negedge clk);
            src_idle_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_idle_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            queued = 0;
            while (queued < ITEMS_PER_PHASE)
            begin
                queue_frame(n);
                queued += n;
            end
            wait_idle();

            // hold off the result side while one-sample frames keep coming
            if (ph == 2)
            begin
                @(negedge clk);
                src_idle_on = 1'b0;
                hold_requests = hold_requests + 1;
                for (int i = 0; i < 60; i++)
                    queue_sample(24'($urandom), 1'b1, 1'b1, rand_position());
                wait_idle();
            end

            // drive the level toward full scale with saturating samples
            if (ph == 4)
            begin
                cfg_write(asld_pkg::CFG_SAMPLE_WIDTH, 36'd4);
                @(negedge clk);
                src_idle_on = 1'b1;
                sink_idle_on = 1'b1;
                for (int i = 0; i < SATURATE_ITEMS; i++)
                begin
                    s = 24'($urandom_range(8, 8388607));
                    if ($urandom_range(0, 1) == 1)
                        s = -s;
                    queue_sample(s, (i % SATURATE_FRAME) == 0,
                                 (i % SATURATE_FRAME) == SATURATE_FRAME - 1,
                                 36'(i / SATURATE_FRAME));
                end
                wait_idle();
            end
        end

        wait_idle();
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("audio_silence_level_detector_top: match");
        else
            $display("audio_silence_level_detector_top: mismatch");
        $finish;
    end

endmodule
